// File: design/clns_pkg.sv
package clns_pkg;

    localparam int MAX_DIGITS = 5;
    localparam int INIT_STROBES = 12;

    localparam int BYTE_W = 8;
    localparam int NUM_W = 16;
    localparam int COL_W = 6;
    localparam int NIB_W = 4;
    localparam int PRE_W = 16;
    localparam int POST_W = 13;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int STROBE_IDX_W = $clog2(INIT_STROBES);

    localparam int IN_DATA_W = 32;
    localparam int IN_USER_W = 3;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_ADDR_W = 3;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [NUM_W-1:0] DIV10_MUL = 16'd52429;
    localparam int DIV10_SHIFT = 19;

    localparam logic [NIB_W-1:0] WAKE_NIB = 4'h3;
    localparam logic [NIB_W-1:0] NIBBLE_MODE_NIB = 4'h2;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

    localparam logic [PRE_W-1:0] POWER_UP_US = 16'd50000;
    localparam logic [POST_W-1:0] WAKE_FIRST_US = 13'd5000;
    localparam logic [POST_W-1:0] WAKE_US = 13'd150;
    localparam logic [POST_W-1:0] SETTLE_US = 13'd50;
    localparam logic [POST_W-1:0] CLEAR_US = 13'd2050;

    localparam logic [BYTE_W-1:0] FUNCTION_SET_RST = 8'd40;
    localparam logic [BYTE_W-1:0] DISPLAY_ON_RST = 8'd12;
    localparam logic [BYTE_W-1:0] ENTRY_MODE_RST = 8'd6;
    localparam logic [BYTE_W-1:0] CLEAR_RST = 8'd1;
    localparam logic [BYTE_W-1:0] ROW0_BASE_RST = 8'd128;
    localparam logic [BYTE_W-1:0] ROW1_BASE_RST = 8'd192;

    typedef enum logic [2:0] {
        KIND_INIT    = 3'd0,
        KIND_COMMAND = 3'd1,
        KIND_CHAR    = 3'd2,
        KIND_NUMBER  = 3'd3,
        KIND_CURSOR  = 3'd4,
        KIND_CLEAR   = 3'd5
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FUNCTION_SET = 3'd0,
        CFG_DISPLAY_ON   = 3'd1,
        CFG_ENTRY_MODE   = 3'd2,
        CFG_CLEAR        = 3'd3,
        CFG_ROW0_BASE    = 3'd4,
        CFG_ROW1_BASE    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] function_set;
        logic [BYTE_W-1:0] display_on;
        logic [BYTE_W-1:0] entry_mode;
        logic [BYTE_W-1:0] clear;
        logic [BYTE_W-1:0] row0_base;
        logic [BYTE_W-1:0] row1_base;
    } cfg_t;

    typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

    typedef struct packed {
        kind_t                  kind;
        logic [BYTE_W-1:0]      byte_value;
        logic                   row_select;
        logic [COL_W-1:0]       column;
        logic [NUM_W-1:0]       quot;
        digits_t                digits;
        logic [DIGIT_CNT_W-1:0] ndig;
    } item_t;

    typedef struct packed {
        logic                    busy;
        logic [STROBE_IDX_W-1:0] idx;
    } seq_status_t;

endpackage

// File: design/char_lcd_nibble_sequencer.sv
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   tuser: kind; tdata: byte_value, number_value, row_select, column
// m_*      out  m_tvalid/m_tready   tuser: rs_level; tdata: nibble, pre_wait_us, post_wait_us; tlast
// cfg_*    in   cfg_we              cfg_addr: register index; cfg_wdata: value
//
// One strobe word per cycle while m_tready is high: init gives 12 strobes, a number 2 per
// digit (2..10), every other request 2. The strobe sequencer sets these counts.
// Requests pass an input stage, four divide-by-ten stages, a digit align stage and the
// strober's output register; kinds 6 and 7 are dropped.
// Reset clears valid bits and loads the default command codes.
// m_tready low holds the output word; the pipeline fills and then drops s_tready.
module char_lcd_nibble_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] byte_value, [23:8] number_value, [24] row_select, [30:25] column
    input  logic [clns_pkg::IN_DATA_W-1:0]      s_tdata,
    // [2:0] kind
    input  logic [clns_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] nibble, [19:4] pre_wait_us, [32:20] post_wait_us
    output logic [clns_pkg::OUT_DATA_W-1:0]     m_tdata,
    // [0] rs_level
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [clns_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [clns_pkg::BYTE_W-1:0]         cfg_wdata
);

    localparam int DIV_STAGES = clns_pkg::MAX_DIGITS - 1;

    clns_pkg::cfg_t          cfg_reg;
    clns_pkg::item_t         in_item;
    logic                    kind_ok;

    logic                    v1_reg;
    clns_pkg::item_t         item1_reg;
    logic                    ready1;

    logic                    div_valid [DIV_STAGES+1];
    clns_pkg::item_t         div_item [DIV_STAGES+1];
    logic                    div_ready [DIV_STAGES+1];

    logic                    va_reg;
    clns_pkg::item_t         itema_reg;
    clns_pkg::item_t         itema_next;
    logic                    readya;

    logic                    seq_ready;
    clns_pkg::seq_status_t   seq_status;
    logic                    out_rs;
    logic [clns_pkg::NIB_W-1:0]  out_nibble;
    logic [clns_pkg::PRE_W-1:0]  out_pre;
    logic [clns_pkg::POST_W-1:0] out_post;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.function_set <= clns_pkg::FUNCTION_SET_RST;
            cfg_reg.display_on <= clns_pkg::DISPLAY_ON_RST;
            cfg_reg.entry_mode <= clns_pkg::ENTRY_MODE_RST;
            cfg_reg.clear <= clns_pkg::CLEAR_RST;
            cfg_reg.row0_base <= clns_pkg::ROW0_BASE_RST;
            cfg_reg.row1_base <= clns_pkg::ROW1_BASE_RST;
        end
        else if (cfg_we)
        begin
            case (clns_pkg::cfg_index_t'(cfg_addr))
                clns_pkg::CFG_FUNCTION_SET: cfg_reg.function_set <= cfg_wdata;
                clns_pkg::CFG_DISPLAY_ON:   cfg_reg.display_on <= cfg_wdata;
                clns_pkg::CFG_ENTRY_MODE:   cfg_reg.entry_mode <= cfg_wdata;
                clns_pkg::CFG_CLEAR:        cfg_reg.clear <= cfg_wdata;
                clns_pkg::CFG_ROW0_BASE:    cfg_reg.row0_base <= cfg_wdata;
                clns_pkg::CFG_ROW1_BASE:    cfg_reg.row1_base <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    // input stage
    always_comb
    begin
        kind_ok = s_tuser inside {[clns_pkg::KIND_INIT : clns_pkg::KIND_CLEAR]};
        in_item.kind = clns_pkg::kind_t'(s_tuser);
        in_item.byte_value = s_tdata[7:0];
        in_item.quot = s_tdata[23:8];
        in_item.row_select = s_tdata[24];
        in_item.column = s_tdata[30:25];
        in_item.digits = '0;
        in_item.ndig = '0;
    end

    assign ready1 = !v1_reg || div_ready[0];
    assign s_tready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ready1)
        begin
            v1_reg <= s_tvalid && kind_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && s_tvalid)
        begin
            item1_reg <= in_item;
        end
    end

    assign div_valid[0] = v1_reg;
    assign div_item[0] = item1_reg;
    assign div_ready[DIV_STAGES] = readya;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        clns_div_stage #(
            .POS(k)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_item   (div_item[k]),
            .in_ready  (div_ready[k]),
            .out_valid (div_valid[k+1]),
            .out_item  (div_item[k+1]),
            .out_ready (div_ready[k+1])
        );
    end

    // digit align: count digits, reorder most significant first
    always_comb
    begin
        itema_next = div_item[DIV_STAGES];
        itema_next.digits[clns_pkg::MAX_DIGITS-1] =
            div_item[DIV_STAGES].quot[3:0];
        itema_next.ndig = 3'd1;
        for (int i = 1; i < clns_pkg::MAX_DIGITS; i++)
        begin
            if (itema_next.digits[i] != 4'd0)
            begin
                itema_next.ndig = clns_pkg::DIGIT_CNT_W'(i + 1);
            end
        end
        for (int i = 0; i < clns_pkg::MAX_DIGITS; i++)
        begin
            itema_next.digits[i] = 4'd0;
            if (i < int'(itema_next.ndig))
            begin
                itema_next.digits[i] = div_item[DIV_STAGES].digits[
                    clns_pkg::DIGIT_IDX_W'(int'(itema_next.ndig) - 1 - i)];
                if (int'(itema_next.ndig) - 1 - i == clns_pkg::MAX_DIGITS - 1)
                begin
                    itema_next.digits[i] = div_item[DIV_STAGES].quot[3:0];
                end
            end
        end
    end

    assign readya = !va_reg || seq_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (readya)
        begin
            va_reg <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (readya && div_valid[DIV_STAGES])
        begin
            itema_reg <= itema_next;
        end
    end

    clns_strober u_strober (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (va_reg),
        .in_item    (itema_reg),
        .in_ready   (seq_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rs     (out_rs),
        .out_nibble (out_nibble),
        .out_pre    (out_pre),
        .out_post   (out_post),
        .out_last   (m_tlast),
        .status     (seq_status)
    );

    assign m_tuser = out_rs;
    assign m_tdata = {7'd0, out_post, out_pre, out_nibble};

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_status.busy |-> seq_status.idx <= 4'(clns_pkg::INIT_STROBES - 1))
        else $error("strobe index past end of run");

    a_power_up_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[19:4] != 16'd0) |->
            (m_tdata[3:0] == clns_pkg::WAKE_NIB && !m_tuser
             && m_tdata[32:20] == clns_pkg::WAKE_FIRST_US))
        else $error("pre-wait on a strobe other than the first wake-up");

    a_bad_kind_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == 3'd6 || s_tuser == 3'd7)) |=> !v1_reg)
        else $error("undefined request kind entered the pipeline");
`endif

endmodule

// File: design/clns_div_stage.sv
module clns_div_stage #(
    parameter int POS = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  clns_pkg::item_t   in_item,
    output logic              in_ready,
    output logic              out_valid,
    output clns_pkg::item_t   out_item,
    input  logic              out_ready
);

    logic                           valid_reg;
    clns_pkg::item_t                item_reg;
    clns_pkg::item_t                item_next;
    logic [2*clns_pkg::NUM_W-1:0]   prod;
    logic [clns_pkg::NUM_W-1:0]     q;
    logic [clns_pkg::NUM_W-1:0]     rem;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        prod = 32'(in_item.quot) * 32'(clns_pkg::DIV10_MUL);
        q = clns_pkg::NUM_W'(prod >> clns_pkg::DIV10_SHIFT);
        rem = in_item.quot - ({q[clns_pkg::NUM_W-4:0], 3'b000} + {q[clns_pkg::NUM_W-2:0], 1'b0});
        item_next = in_item;
        item_next.quot = q;
        item_next.digits[POS] = rem[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;

endmodule

// File: design/clns_strober.sv
module clns_strober (
    input  logic                             clk,
    input  logic                             rst_n,
    input  clns_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    input  clns_pkg::item_t                  in_item,
    output logic                             in_ready,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_rs,
    output logic [clns_pkg::NIB_W-1:0]       out_nibble,
    output logic [clns_pkg::PRE_W-1:0]       out_pre,
    output logic [clns_pkg::POST_W-1:0]      out_post,
    output logic                             out_last,
    output clns_pkg::seq_status_t            status
);

    localparam int IW = clns_pkg::STROBE_IDX_W;

    logic                          busy_reg;
    logic [IW-1:0]                 idx_reg;
    clns_pkg::item_t               item_reg;

    logic                          valid_reg;
    logic                          rs_reg;
    logic [clns_pkg::NIB_W-1:0]    nib_reg;
    logic [clns_pkg::PRE_W-1:0]    pre_reg;
    logic [clns_pkg::POST_W-1:0]   post_reg;
    logic                          last_reg;

    logic                          out_free;
    logic                          load;
    logic                          take;
    logic [2:0]                    byte_idx;
    logic [IW-1:0]                 total;
    logic [clns_pkg::BYTE_W-1:0]   sel_byte;
    logic [3:0]                    digit;
    logic                          rs_next;
    logic [clns_pkg::NIB_W-1:0]    nib_next;
    logic [clns_pkg::PRE_W-1:0]    pre_next;
    logic [clns_pkg::POST_W-1:0]   post_next;
    logic                          last_next;

    assign out_free = !valid_reg || out_ready;
    assign load = busy_reg && out_free;
    assign in_ready = !busy_reg || (load && last_next);
    assign take = in_ready && in_valid;
    assign byte_idx = idx_reg[IW-1:1];

    always_comb
    begin
        digit = 4'd0;
        if (byte_idx < 3'(clns_pkg::MAX_DIGITS))
        begin
            digit = item_reg.digits[byte_idx];
        end

        total = 4'd2;
        rs_next = 1'b0;
        sel_byte = cfg.clear;
        case (item_reg.kind)
            clns_pkg::KIND_INIT:
            begin
                total = 4'(clns_pkg::INIT_STROBES);
                case (byte_idx)
                    3'd2:    sel_byte = cfg.function_set;
                    3'd3:    sel_byte = cfg.display_on;
                    3'd4:    sel_byte = cfg.entry_mode;
                    default: sel_byte = cfg.clear;
                endcase
            end
            clns_pkg::KIND_COMMAND:
            begin
                sel_byte = item_reg.byte_value;
            end
            clns_pkg::KIND_CHAR:
            begin
                rs_next = 1'b1;
                sel_byte = item_reg.byte_value;
            end
            clns_pkg::KIND_NUMBER:
            begin
                rs_next = 1'b1;
                total = {item_reg.ndig, 1'b0};
                sel_byte = clns_pkg::ASCII_ZERO | {4'd0, digit};
            end
            clns_pkg::KIND_CURSOR:
            begin
                sel_byte = (item_reg.row_select ? cfg.row1_base : cfg.row0_base)
                           + {2'b00, item_reg.column};
            end
            default:
            begin
                sel_byte = cfg.clear;
            end
        endcase

        last_next = (idx_reg == total - 4'd1);
        pre_next = '0;
        nib_next = idx_reg[0] ? sel_byte[3:0] : sel_byte[7:4];
        post_next = '0;
        if (idx_reg[0])
        begin
            // the clear command needs the long settle
            if (item_reg.kind == clns_pkg::KIND_CLEAR
                || (item_reg.kind == clns_pkg::KIND_INIT && last_next))
            begin
                post_next = clns_pkg::CLEAR_US;
            end
            else
            begin
                post_next = clns_pkg::SETTLE_US;
            end
        end

        // wake-up nibbles and the nibble-mode nibble ahead of the init commands
        if (item_reg.kind == clns_pkg::KIND_INIT && idx_reg < 4'd4)
        begin
            nib_next = (idx_reg == 4'd3) ? clns_pkg::NIBBLE_MODE_NIB : clns_pkg::WAKE_NIB;
            if (idx_reg == 4'd0)
            begin
                pre_next = clns_pkg::POWER_UP_US;
                post_next = clns_pkg::WAKE_FIRST_US;
            end
            else
            begin
                post_next = clns_pkg::WAKE_US;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                idx_reg <= '0;
            end
            else if (load)
            begin
                if (last_next)
                begin
                    busy_reg <= 1'b0;
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 4'd1;
                end
            end

            if (out_free)
            begin
                valid_reg <= load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
        if (load)
        begin
            rs_reg <= rs_next;
            nib_reg <= nib_next;
            pre_reg <= pre_next;
            post_reg <= post_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rs = rs_reg;
    assign out_nibble = nib_reg;
    assign out_pre = pre_reg;
    assign out_post = post_reg;
    assign out_last = last_reg;
    assign status.busy = busy_reg;
    assign status.idx = idx_reg;

endmodule
